// ===== rtl/core/tclp_pkg.sv =====
// Shared constants, types and helper functions of the text command line parser.
package tclp_pkg;

	// Default sizes of the line buffer limit and the argument list.
	localparam int LINE_LIMIT_DEF     = 128;
	localparam int ARGUMENT_COUNT_DEF = 4;

	// Command identifiers.
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_INFO = 2'd1;
	localparam logic [1:0] CMD_VOLT = 2'd2;
	localparam logic [1:0] CMD_BOTH = 2'd3;

	// Byte codes the parser reacts to.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	// Name lengths of the two commands.
	localparam logic [2:0] INFO_LEN = 3'd4;
	localparam logic [2:0] VOLT_LEN = 3'd7;

	// Phase of the argument currently being read.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SPACE  = 3'd1,
		PH_SIGN   = 3'd2,
		PH_DIGITS = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	// Expected character of "INFO" at a name position.
	function automatic logic [7:0] info_char(input logic [1:0] pos);
		logic [7:0] c;
		unique case (pos)
			2'd0: c = 8'h49;
			2'd1: c = 8'h4E;
			2'd2: c = 8'h46;
			default: c = 8'h4F;
		endcase
		return c;
	endfunction

	// Expected character of "VOLT_DC" at a name position.
	function automatic logic [7:0] volt_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h56;
			3'd1: c = 8'h4F;
			3'd2: c = 8'h4C;
			3'd3: c = 8'h54;
			3'd4: c = 8'h5F;
			3'd5: c = 8'h44;
			3'd6: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Command id of a finished name, or CMD_NONE when it matches neither.
	function automatic logic [1:0] name_match(input logic [1:0] cand, input logic [2:0] pos);
		logic [1:0] id;
		if (cand[0] && pos == INFO_LEN) begin
			id = CMD_INFO;
		end else if (cand[1] && pos == VOLT_LEN) begin
			id = CMD_VOLT;
		end else begin
			id = CMD_NONE;
		end
		return id;
	endfunction

	// Final value of an argument from its magnitude, sign and overflow.
	function automatic logic [31:0] commit_value(input logic [31:0] v, input logic neg,
			input logic sat);
		logic [31:0] r;
		if (sat) begin
			r = 32'hFFFF_FFFF;
		end else if (neg) begin
			r = 32'd0 - v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/text_command_line_parser.sv =====
// Top level of the text command line parser: byte input stage, line parser and result register.

// Bytes enter one a cycle through byte_valid/byte_ready and are parsed as lines of the form
// NAME;a;b;c;d ended by a newline. The name must be INFO (id 1) or VOLT_DC (id 2); each
// argument is read as an unsigned 32-bit decimal with optional sign, saturating on overflow,
// and a missing or non-numeric argument reads as 0. A valid line gives one word on the result
// channel once its newline has passed the input register and the result register; invalid
// lines, and lines that reach LINE_LIMIT-1 bytes without a newline, give nothing. The block
// takes one byte every cycle: each byte passes an input register, one compare and
// multiply-by-ten update of the line state, and the result register, and it keeps taking
// bytes while a result waits unless a second result would have to overwrite it.
module text_command_line_parser #(
	parameter int LINE_LIMIT     = tclp_pkg::LINE_LIMIT_DEF,
	parameter int ARGUMENT_COUNT = tclp_pkg::ARGUMENT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  command_id,
	output logic [31:0] argument_0,
	output logic [31:0] argument_1,
	output logic [31:0] argument_2,
	output logic [31:0] argument_3
);

	localparam int LL_W  = $clog2(LINE_LIMIT);
	localparam int FN_W  = $clog2(ARGUMENT_COUNT + 2);
	localparam int IDX_W = (ARGUMENT_COUNT > 1) ? $clog2(ARGUMENT_COUNT) : 1;
	localparam logic [FN_W-1:0] FN_LAST = FN_W'(ARGUMENT_COUNT);
	localparam logic [FN_W-1:0] FN_DONE = FN_W'(ARGUMENT_COUNT + 1);
	localparam logic [LL_W-1:0] LL_MAX  = LL_W'(LINE_LIMIT - 1);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;

	// Line state.
	logic [LL_W-1:0]   ll_q, ll_d;
	logic [FN_W-1:0]   fn_q, fn_d;
	logic [1:0]        cand_q, cand_d;
	logic [2:0]        pos_q, pos_d;
	tclp_pkg::phase_t  ph_q, ph_d;
	logic              neg_q, neg_d;
	logic              sat_q, sat_d;
	logic              cut_q, cut_d;
	logic [31:0]       args_q [ARGUMENT_COUNT];
	logic [31:0]       args_d [ARGUMENT_COUNT];

	// Result of the byte in the input stage.
	logic        res_valid;
	logic [1:0]  res_id;
	logic [31:0] res_args [4];

	// A byte that gives no result moves on even while a result word waits.
	assign out_free   = !result_valid || result_ready;
	assign advance    = valid_s1 && (out_free || !res_valid);
	assign byte_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Next line state and result for the byte in the input stage.
	always_comb begin
		logic [IDX_W-1:0] slot;
		logic [31:0]      cur;
		logic [35:0]      prod;
		logic             delim;
		logic             digit;
		logic             space;
		logic             do_clear;
		logic [LL_W-1:0]  ll_inc;
		logic [1:0]       id;
		logic [7:0]       b;

		b        = byte_s1;
		ll_d     = ll_q;
		fn_d     = fn_q;
		cand_d   = cand_q;
		pos_d    = pos_q;
		ph_d     = ph_q;
		neg_d    = neg_q;
		sat_d    = sat_q;
		cut_d    = cut_q;
		args_d   = args_q;
		do_clear = 1'b0;
		slot     = IDX_W'(fn_q - FN_W'(1));
		cur      = args_q[slot];
		prod     = 36'd0;
		id       = tclp_pkg::CMD_NONE;
		ll_inc   = ll_q + LL_W'(1);
		delim    = (b == tclp_pkg::CH_SEMI) || (b == tclp_pkg::CH_CR);
		digit    = (b >= tclp_pkg::CH_ZERO) && (b <= tclp_pkg::CH_NINE);
		space    = (b == tclp_pkg::CH_SPACE) || (b == tclp_pkg::CH_HT) ||
			(b == tclp_pkg::CH_VT) || (b == tclp_pkg::CH_FF);

		res_valid = 1'b0;
		for (int k = 0; k < 4; k++) begin
			res_args[k] = (k < ARGUMENT_COUNT) ? args_q[k] : 32'd0;
		end

		if (b == tclp_pkg::CH_LF) begin
			// End of line: close an open argument and report a recognized command.
			if (fn_q == FN_W'(0)) begin
				id = tclp_pkg::name_match(cand_q, pos_q);
			end else begin
				id = cand_q;
				if (fn_q <= FN_LAST && ph_q != tclp_pkg::PH_IDLE) begin
					for (int k = 0; k < 4; k++) begin
						if (k < ARGUMENT_COUNT && IDX_W'(k) == slot) begin
							res_args[k] = tclp_pkg::commit_value(cur, neg_q, sat_q);
						end
					end
				end
			end
			res_valid = (id != tclp_pkg::CMD_NONE);
			do_clear  = 1'b1;
		end else begin
			if (!cut_q) begin
				if (b == tclp_pkg::CH_NUL) begin
					cut_d = 1'b1;
				end else if (fn_q == FN_W'(0)) begin
					// Name token.
					if (b == tclp_pkg::CH_SEMI) begin
						if (pos_q != 3'd0) begin
							id = tclp_pkg::name_match(cand_q, pos_q);
							if (id != tclp_pkg::CMD_NONE) begin
								cand_d = id;
								fn_d   = FN_W'(1);
								ph_d   = tclp_pkg::PH_IDLE;
							end else begin
								cand_d = tclp_pkg::CMD_NONE;
								fn_d   = FN_DONE;
							end
						end
					end else begin
						if (!(pos_q < tclp_pkg::INFO_LEN && b == tclp_pkg::info_char(pos_q[1:0]))) begin
							cand_d[0] = 1'b0;
						end
						if (!(pos_q < tclp_pkg::VOLT_LEN && b == tclp_pkg::volt_char(pos_q))) begin
							cand_d[1] = 1'b0;
						end
						if (pos_q < 3'd7) begin
							pos_d = pos_q + 3'd1;
						end
					end
				end else if (fn_q <= FN_LAST) begin
					// Argument token.
					if (!(ph_q == tclp_pkg::PH_IDLE && delim)) begin
						if (ph_q == tclp_pkg::PH_IDLE) begin
							ph_d  = tclp_pkg::PH_SPACE;
							neg_d = 1'b0;
							sat_d = 1'b0;
							cur   = 32'd0;
						end
						if (delim) begin
							cur  = tclp_pkg::commit_value(cur, neg_d, sat_d);
							fn_d = fn_q + FN_W'(1);
							ph_d = tclp_pkg::PH_IDLE;
						end else if (ph_d == tclp_pkg::PH_SPACE && space) begin
							ph_d = tclp_pkg::PH_SPACE;
						end else if (ph_d == tclp_pkg::PH_SPACE &&
								(b == tclp_pkg::CH_PLUS || b == tclp_pkg::CH_MINUS)) begin
							neg_d = (b == tclp_pkg::CH_MINUS);
							ph_d  = tclp_pkg::PH_SIGN;
						end else if (ph_d == tclp_pkg::PH_SPACE || ph_d == tclp_pkg::PH_SIGN ||
								ph_d == tclp_pkg::PH_DIGITS) begin
							if (digit) begin
								// Multiply by ten and add the digit, saturating on overflow.
								ph_d = tclp_pkg::PH_DIGITS;
								if (!sat_d) begin
									prod = ({4'd0, cur} << 3) + ({4'd0, cur} << 1) +
										{32'd0, b[3:0]};
									if (prod[35:32] != 4'd0) begin
										sat_d = 1'b1;
									end else begin
										cur = prod[31:0];
									end
								end
							end else begin
								ph_d = tclp_pkg::PH_SKIP;
							end
						end
						args_d[slot] = cur;
					end
				end
			end
			ll_d = ll_inc;
			if (ll_inc >= LL_MAX) begin
				do_clear = 1'b1;
			end
		end

		res_id = id;

		// Start a fresh line.
		if (do_clear) begin
			ll_d   = '0;
			fn_d   = '0;
			cand_d = tclp_pkg::CMD_BOTH;
			pos_d  = 3'd0;
			ph_d   = tclp_pkg::PH_IDLE;
			neg_d  = 1'b0;
			sat_d  = 1'b0;
			cut_d  = 1'b0;
			for (int k = 0; k < ARGUMENT_COUNT; k++) begin
				args_d[k] = 32'd0;
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ll_q   <= '0;
			fn_q   <= '0;
			cand_q <= tclp_pkg::CMD_BOTH;
			pos_q  <= 3'd0;
			ph_q   <= tclp_pkg::PH_IDLE;
			neg_q  <= 1'b0;
			sat_q  <= 1'b0;
			cut_q  <= 1'b0;
			for (int k = 0; k < ARGUMENT_COUNT; k++) begin
				args_q[k] <= 32'd0;
			end
		end else if (advance) begin
			ll_q   <= ll_d;
			fn_q   <= fn_d;
			cand_q <= cand_d;
			pos_q  <= pos_d;
			ph_q   <= ph_d;
			neg_q  <= neg_d;
			sat_q  <= sat_d;
			cut_q  <= cut_d;
			args_q <= args_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && res_valid) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			command_id <= res_id;
			argument_0 <= res_args[0];
			argument_1 <= res_args[1];
			argument_2 <= res_args[2];
			argument_3 <= res_args[3];
		end
	end

	// A held result must never be overwritten by the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !(advance && res_valid))
		else $error("result overwritten while stalled");

	// A delivered result always carries a recognized command.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (command_id == tclp_pkg::CMD_INFO || command_id == tclp_pkg::CMD_VOLT))
		else $error("result with unknown command id");

	// The line length is cleared before it reaches the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		ll_q < LL_MAX)
		else $error("line length past limit");

	// An argument is only read while an argument field is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != tclp_pkg::PH_IDLE) |-> (fn_q != FN_W'(0) && fn_q <= FN_LAST))
		else $error("argument phase outside argument field");

endmodule
